FILE: sv/cpws_pkg.sv
package cpws_pkg;

   // Field widths fixed by the channel definitions
   localparam int FUNC_BITS       = 1;
   localparam int TIMESTAMP_BITS  = 16;
   localparam int SUM_BITS        = 19;
   localparam int SPEED_BITS      = 32;
   localparam int WRAP_BITS       = 17;
   localparam int NUMERATOR_BITS  = 32;
   localparam int THRESHOLD_BITS  = 16;
   localparam int COUNT_BITS      = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 32;

   // Parameter defaults
   localparam int WINDOW_STAMPS_DEFAULT = 6;
   localparam int STAMP_BITS_DEFAULT    = 16;

   // Register reset values
   localparam logic [WRAP_BITS-1:0]      WRAP_PERIOD_RESET       = 17'd65000;
   localparam logic [NUMERATOR_BITS-1:0] SPEED_NUMERATOR_RESET   = 32'd1474560000;
   localparam logic [THRESHOLD_BITS-1:0] CAPTURE_THRESHOLD_RESET = 16'd100;

   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

   // Item codes
   localparam logic [FUNC_BITS-1:0] FUNC_CAPTURE = 1'b0;
   localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRAP_PERIOD       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_NUMERATOR   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAPTURE_THRESHOLD = 2'd2;

   typedef enum logic [1:0] {
      OUT_PLAIN = 2'd0,
      OUT_SPEED = 2'd1,
      OUT_SAT   = 2'd2
   } out_mode_type;

   typedef struct packed {
      logic         capture_load;
      logic         tick_load;
      logic         sum_step;
      logic         div_step;
      logic         result_load;
      out_mode_type out_mode;
   } cpws_cmd_type;

   typedef struct packed {
      logic update_due;
      logic sum_zero;
   } cpws_status_type;

endpackage

FILE: sv/cpws_req_if.sv
interface cpws_req_if;
   import cpws_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FUNC_BITS-1:0]      func;
   logic [TIMESTAMP_BITS-1:0] timestamp;

   modport source (output valid, output func, output timestamp, input ready);
   modport sink   (input valid, input func, input timestamp, output ready);
endinterface

FILE: sv/cpws_rsp_if.sv
interface cpws_rsp_if;
   import cpws_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SUM_BITS-1:0]   period_sum;
   logic [SPEED_BITS-1:0] speed;
   logic                  speed_valid;
   logic                  speed_saturated;

   modport source (output valid, output period_sum, output speed, output speed_valid,
                   output speed_saturated, input ready);
   modport sink   (input valid, input period_sum, input speed, input speed_valid,
                   input speed_saturated, output ready);
endinterface

FILE: sv/cpws_datapath.sv
module cpws_datapath #(
   parameter int WINDOW_STAMPS = cpws_pkg::WINDOW_STAMPS_DEFAULT,
   parameter int STAMP_BITS    = cpws_pkg::STAMP_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cpws_pkg::cpws_cmd_type                cmd,
   output cpws_pkg::cpws_status_type             status,
   input  logic [cpws_pkg::TIMESTAMP_BITS-1:0]   timestamp,
   input  logic                                  csr_write_enable,
   input  logic [cpws_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cpws_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output logic [cpws_pkg::SUM_BITS-1:0]         period_sum,
   output logic [cpws_pkg::SPEED_BITS-1:0]       speed,
   output logic                                  speed_valid,
   output logic                                  speed_saturated
);
   import cpws_pkg::*;

   localparam int TERM_BITS = (STAMP_BITS > WRAP_BITS) ? STAMP_BITS : WRAP_BITS;
   localparam int ACC_BITS  = ((TERM_BITS > SUM_BITS) ? TERM_BITS : SUM_BITS) + 1;

   logic [WRAP_BITS-1:0]      wrap_ff;
   logic [NUMERATOR_BITS-1:0] numerator_ff;
   logic [THRESHOLD_BITS-1:0] threshold_ff;

   logic [STAMP_BITS-1:0] window_ff  [WINDOW_STAMPS];
   logic [STAMP_BITS-1:0] window_in  [WINDOW_STAMPS];
   logic [STAMP_BITS-1:0] scratch_ff [WINDOW_STAMPS];
   logic [STAMP_BITS-1:0] scratch_in [WINDOW_STAMPS];
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [SUM_BITS-1:0]   window_sum_ff;
   logic [SUM_BITS-1:0]   window_sum_in;

   logic [TERM_BITS-1:0]  term;
   logic [ACC_BITS-1:0]   acc_wide;

   logic [SUM_BITS-1:0]   rem_ff;
   logic [SUM_BITS-1:0]   rem_in;
   logic [SPEED_BITS-1:0] quo_ff;
   logic [SPEED_BITS-1:0] quo_in;
   logic [SUM_BITS:0]     div_shift;
   logic [SUM_BITS:0]     div_diff;
   logic                  div_fits;

   logic [SUM_BITS-1:0]   period_sum_ff;
   logic [SPEED_BITS-1:0] speed_ff;
   logic                  speed_valid_ff;
   logic                  speed_saturated_ff;

   // Configuration registers; writes to an unused index drop
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff      <= WRAP_PERIOD_RESET;
         numerator_ff <= SPEED_NUMERATOR_RESET;
         threshold_ff <= CAPTURE_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WRAP_PERIOD:       wrap_ff      <= csr_write_data[WRAP_BITS-1:0];
            CSR_SPEED_NUMERATOR:   numerator_ff <= csr_write_data[NUMERATOR_BITS-1:0];
            CSR_CAPTURE_THRESHOLD: threshold_ff <= csr_write_data[THRESHOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Interval term from the two lowest scratch taps
   always_comb begin
      logic [TERM_BITS-1:0] hi;
      logic [TERM_BITS-1:0] lo;
      logic [TERM_BITS-1:0] back;
      logic [TERM_BITS-1:0] wrap_ext;
      hi       = TERM_BITS'(scratch_ff[1]);
      lo       = TERM_BITS'(scratch_ff[0]);
      wrap_ext = TERM_BITS'(wrap_ff);
      back     = lo - hi;
      if (hi >= lo) begin
         term = hi - lo;
      end else if (wrap_ext >= back) begin
         term = wrap_ext - back;
      end else begin
         term = '0;
      end
      acc_wide = ACC_BITS'(window_sum_ff) + ACC_BITS'(term);
   end

   always_comb begin
      for (int k = 0; k < WINDOW_STAMPS; k++) begin
         window_in[k]  = window_ff[k];
         scratch_in[k] = scratch_ff[k];
      end
      count_in      = count_ff;
      window_sum_in = window_sum_ff;
      if (cmd.capture_load) begin
         // Advance the window and copy it for the summing pass
         for (int k = 0; k < WINDOW_STAMPS - 1; k++) begin
            window_in[k] = window_ff[k+1];
         end
         window_in[WINDOW_STAMPS-1] = STAMP_BITS'(timestamp);
         for (int k = 0; k < WINDOW_STAMPS; k++) begin
            scratch_in[k] = window_in[k];
         end
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
         window_sum_in = '0;
      end else if (cmd.sum_step) begin
         for (int k = 0; k < WINDOW_STAMPS - 1; k++) begin
            scratch_in[k] = scratch_ff[k+1];
         end
         if (acc_wide > ACC_BITS'(SUM_MAX)) begin
            window_sum_in = SUM_MAX;
         end else begin
            window_sum_in = acc_wide[SUM_BITS-1:0];
         end
      end else if (cmd.tick_load) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_STAMPS; k++) begin
            window_ff[k] <= '0;
         end
         count_ff      <= '0;
         window_sum_ff <= '0;
      end else begin
         window_ff     <= window_in;
         count_ff      <= count_in;
         window_sum_ff <= window_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      scratch_ff <= scratch_in;
   end

   // Restoring divider, one quotient bit a step
   assign div_shift = {rem_ff, quo_ff[SPEED_BITS-1]};
   assign div_diff  = div_shift - {1'b0, window_sum_ff};
   assign div_fits  = (div_shift >= {1'b0, window_sum_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.tick_load) begin
         rem_in = '0;
         quo_in = numerator_ff;
      end else if (cmd.div_step) begin
         rem_in = div_fits ? div_diff[SUM_BITS-1:0] : div_shift[SUM_BITS-1:0];
         quo_in = {quo_ff[SPEED_BITS-2:0], div_fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         period_sum_ff <= window_sum_ff;
         unique case (cmd.out_mode)
            OUT_SPEED: begin
               speed_ff           <= quo_ff;
               speed_valid_ff     <= 1'b1;
               speed_saturated_ff <= 1'b0;
            end
            OUT_SAT: begin
               speed_ff           <= SPEED_MAX;
               speed_valid_ff     <= 1'b1;
               speed_saturated_ff <= 1'b1;
            end
            default: begin
               speed_ff           <= '0;
               speed_valid_ff     <= 1'b0;
               speed_saturated_ff <= 1'b0;
            end
         endcase
      end
   end

   assign status.update_due = (count_ff > COUNT_BITS'(threshold_ff));
   assign status.sum_zero   = (window_sum_ff == '0);

   assign period_sum      = period_sum_ff;
   assign speed           = speed_ff;
   assign speed_valid     = speed_valid_ff;
   assign speed_saturated = speed_saturated_ff;

endmodule

FILE: sv/cpws_controller.sv
module cpws_controller #(
   parameter int WINDOW_STAMPS = cpws_pkg::WINDOW_STAMPS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [cpws_pkg::FUNC_BITS-1:0]   req_func,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  cpws_pkg::cpws_status_type        status,
   output cpws_pkg::cpws_cmd_type           cmd
);
   import cpws_pkg::*;

   localparam int SUM_STEPS  = WINDOW_STAMPS - 1;
   localparam int STEP_COUNT = (SUM_STEPS > SPEED_BITS) ? SUM_STEPS : SPEED_BITS;
   localparam int STEP_BITS  = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [STEP_BITS-1:0] step_ff;
   logic [STEP_BITS-1:0] step_in;
   out_mode_type         mode_ff;
   out_mode_type         mode_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 accept;
   logic                 rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      mode_in          = mode_ff;
      cmd              = '0;
      cmd.out_mode     = mode_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               if (req_func == FUNC_CAPTURE) begin
                  cmd.capture_load = 1'b1;
                  mode_in          = OUT_PLAIN;
                  state_in         = ST_SUM;
               end else if (status.update_due) begin
                  cmd.tick_load = 1'b1;
                  if (status.sum_zero) begin
                     mode_in  = OUT_SAT;
                     state_in = ST_DONE;
                  end else begin
                     mode_in  = OUT_SPEED;
                     state_in = ST_DIV;
                  end
               end else begin
                  mode_in  = OUT_PLAIN;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SPEED_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output slot frees up
            if (rsp_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         mode_ff      <= OUT_PLAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/capture_period_wheel_speed_unit.sv
// Wheel-speed meter fed by input-capture timestamps. Each request beat is either a
// capture (func = 0), which shifts its timestamp into a window of WINDOW_STAMPS entries,
// counts the capture (saturating at 65535) and re-sums the WINDOW_STAMPS-1 intervals,
// or a control tick (func = 1), which, when the capture count exceeds
// capture_threshold, reports speed = speed_numerator / period_sum in Q16.16 with
// speed_valid set and clears the count. A zero sum gives all-ones speed with
// speed_saturated set. A backward timestamp step has wrap_period added; the sum
// saturates at 2^19-1. Every request beat yields exactly one response beat.
// A capture shifts the window and then runs the sum pass, one window interval
// summed per cycle, before the response register loads; an updating tick with a
// nonzero sum runs a restoring divider producing one quotient bit per cycle before
// the response loads; any other tick goes straight to loading the response.
// One item is in flight at a time; the next request beat is taken while the previous
// response still waits in its output register, and a stalled response holds the
// block only when the next result is ready to load.
// Registers are written through csr_* at any idle time: 0 wrap_period,
// 1 speed_numerator, 2 capture_threshold; other indexes are ignored.
module capture_period_wheel_speed_unit #(
   parameter int WINDOW_STAMPS = cpws_pkg::WINDOW_STAMPS_DEFAULT,
   parameter int STAMP_BITS    = cpws_pkg::STAMP_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   cpws_req_if.sink                            req_bus,
   cpws_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [cpws_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cpws_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import cpws_pkg::*;

   cpws_cmd_type    cmd;
   cpws_status_type status;

   // Sequencer: accepts beats, steps the sum and divide passes, loads the result
   cpws_controller #(
      .WINDOW_STAMPS (WINDOW_STAMPS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Window, count, interval summer, divider, configuration and result registers
   cpws_datapath #(
      .WINDOW_STAMPS (WINDOW_STAMPS),
      .STAMP_BITS    (STAMP_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .timestamp        (req_bus.timestamp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .period_sum       (rsp_bus.period_sum),
      .speed            (rsp_bus.speed),
      .speed_valid      (rsp_bus.speed_valid),
      .speed_saturated  (rsp_bus.speed_saturated)
   );

endmodule
